// ===== sv/clt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Types, token codes and character helpers shared by the command-line
// tokenizer modules.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int MAX_TOKEN_LENGTH = 255;
	localparam logic [7:0] LEN_CAP =
		8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);

	localparam logic [3:0] KIND_WORD      = 4'd0;
	localparam logic [3:0] KIND_COMMA     = 4'd1;
	localparam logic [3:0] KIND_SEMICOLON = 4'd2;
	localparam logic [3:0] KIND_PLUS      = 4'd3;
	localparam logic [3:0] KIND_SLASH     = 4'd4;
	localparam logic [3:0] KIND_COLON     = 4'd5;
	localparam logic [3:0] KIND_AT        = 4'd6;
	localparam logic [3:0] KIND_TEXT      = 4'd7;
	localparam logic [3:0] KIND_LINE_END  = 4'd8;
	localparam logic [3:0] KIND_CMD_END   = 4'd9;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [4:0] HEX_NONE  = 5'd16;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_WORD    = 2'd1;
	localparam logic [1:0] MODE_TEXT    = 2'd2;
	localparam logic [1:0] MODE_DISCARD = 2'd3;

	typedef struct packed {
		logic [7:0] char_in;
		logic       outermost;
	} in_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic        is_number;
		logic        is_hex;
		logic [15:0] number_value;
		logic [7:0]  token_length;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic        is_number;
		logic        is_hex;
		logic [15:0] value;
		logic [7:0]  length;
	} token_t;

	// One queue entry: a token, optionally followed by a delimiter token.
	typedef struct packed {
		token_t     tok0;
		logic       two;
		logic [3:0] kind1;
	} entry_t;

	typedef struct packed {
		logic [15:0] value;
		logic        num;
		logic        hex;
		logic        zero_first;
		logic [7:0]  len;
	} word_t;

	function automatic logic [7:0] normalize(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == CH_CR)
			r = CH_LF;
		if (c == CH_TAB)
			r = CH_SPACE;
		return r;
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c, input logic outer);
		logic [3:0] k;
		case (c)
			CH_LF:    k = outer ? KIND_CMD_END : KIND_LINE_END;
			CH_COMMA: k = KIND_COMMA;
			CH_SEMI:  k = KIND_SEMICOLON;
			CH_PLUS:  k = KIND_PLUS;
			CH_SLASH: k = KIND_SLASH;
			CH_COLON: k = KIND_COLON;
			CH_AT:    k = KIND_AT;
			default:  k = KIND_WORD;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] bump(input logic [7:0] len);
		return (len < LEN_CAP) ? len + 8'd1 : len;
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = {3'b000, HEX_NONE};
		if (is_dec(c))
			d = c - CH_ZERO;
		else if ((c >= CH_LC_A) && (c <= CH_LC_F))
			d = c - CH_LC_A + 8'd10;
		else if ((c >= CH_UC_A) && (c <= CH_UC_F))
			d = c - CH_UC_A + 8'd10;
		return d[4:0];
	endfunction

	function automatic word_t word_char(input word_t w, input logic [7:0] c);
		word_t      r;
		logic [4:0] d;
		r = w;
		d = hex_val(c);
		if ((w.len == 8'd0) && (c == CH_ZERO))
			r.zero_first = 1'b1;
		r.len = bump(w.len);
		if ((w.len == 8'd1) && r.zero_first && ((c == CH_LC_X) || (c == CH_UC_X))) begin
			r.hex = 1'b1;
		end else if (!w.hex) begin
			r.num = w.num && is_dec(c);
			if (r.num)
				r.value = (w.value << 3) + (w.value << 1) + {12'd0, c[3:0]};
		end else begin
			r.num = w.num && (d != HEX_NONE);
			r.hex = r.num;
			if (r.num)
				r.value = (w.value << 4) + {12'd0, d[3:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/clt_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_lexer
// Front end: while take is high, normalizes and classifies one character per
// cycle, keeps the lexer state, writes the tokens it ends as one queue entry.
// ----------------------------------------------------------------------------
module clt_lexer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              take,
	input  clt_pkg::in_t     item,
	output logic             wr,
	output clt_pkg::entry_t  entry
);
	import clt_pkg::*;

	logic [1:0]  mode_q, mode_n;
	logic [15:0] depth_q, depth_n;
	word_t       word_q, word_n;
	word_t       word_init;
	logic [7:0]  c;
	logic [3:0]  kind;
	logic        emit;

	assign c    = normalize(item.char_in);
	assign kind = single_kind(c, item.outermost);

	always_comb begin
		word_init = '0;
		word_init.num = 1'b1;
		mode_n  = mode_q;
		depth_n = depth_q;
		word_n  = word_q;
		emit    = 1'b0;
		entry   = '0;
		case (mode_q)
			MODE_DISCARD: begin
			end
			MODE_TEXT: begin
				if (c != CH_LF)
					word_n.len = bump(word_q.len);
				if (c == CH_LPAREN)
					depth_n = depth_q + 16'd1;
				if (c == CH_RPAREN)
					depth_n = depth_q - 16'd1;
				if (depth_n == 16'd0) begin
					emit = 1'b1;
					entry.tok0.kind   = KIND_TEXT;
					entry.tok0.length = word_n.len;
					mode_n = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if ((kind != KIND_WORD) || (c == CH_SPACE)) begin
					emit = 1'b1;
					entry.tok0.kind      = KIND_WORD;
					entry.tok0.is_number = word_q.num;
					entry.tok0.is_hex    = word_q.hex;
					entry.tok0.value     = word_q.value;
					entry.tok0.length    = word_q.len;
					entry.two   = (kind != KIND_WORD);
					entry.kind1 = kind;
					mode_n = (kind == KIND_SEMICOLON) ? MODE_DISCARD : MODE_IDLE;
				end else begin
					word_n = word_char(word_q, c);
				end
			end
			default: begin
				if (c == CH_SPACE) begin
				end else if (kind != KIND_WORD) begin
					emit = 1'b1;
					entry.tok0.kind   = kind;
					entry.tok0.length = 8'd1;
					if (kind == KIND_SEMICOLON)
						mode_n = MODE_DISCARD;
				end else if (c == CH_LPAREN) begin
					mode_n     = MODE_TEXT;
					depth_n    = 16'd1;
					word_n.len = 8'd1;
				end else begin
					mode_n = MODE_WORD;
					word_n = word_char(word_init, c);
				end
			end
		endcase
	end

	assign wr = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			depth_q <= '0;
			word_q  <= '0;
		end else if (take) begin
			mode_q  <= mode_n;
			depth_q <= depth_n;
			word_q  <= word_n;
		end
	end

`ifndef ASSERT_OFF
	a_discard_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DISCARD) |=> (mode_q == MODE_DISCARD))
		else $error("discard mode left before reset");
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DISCARD) |-> !wr)
		else $error("token written while discarding");
	a_text_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_TEXT) |-> (depth_q != 16'd0))
		else $error("text mode with zero nesting depth");
`endif

endmodule
`default_nettype wire

// ===== sv/clt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue
// Short entry queue between the lexer and the result stage.
// ----------------------------------------------------------------------------
module clt_queue #(
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr,
	input  clt_pkg::entry_t  wdata,
	input  wire              rd,
	output clt_pkg::entry_t  rdata,
	output logic             full,
	output logic             empty
);
	import clt_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			if (do_rd)
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("entry written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && empty))
		else $error("entry read from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== sv/clt_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_emit
// Back end: splits each queue entry into one or two results and holds the
// oldest result in an output register until it is popped.
// ----------------------------------------------------------------------------
module clt_emit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_empty,
	input  clt_pkg::entry_t  head,
	output logic             q_rd,
	output clt_pkg::out_t    result,
	output logic             empty,
	input  wire              pop
);
	import clt_pkg::*;

	logic  valid_q;
	logic  phase_q;
	out_t  result_q;
	out_t  next_res;
	logic  load;

	assign load = !q_empty && (!valid_q || pop);

	always_comb begin
		next_res = '0;
		if (phase_q) begin
			next_res.token_kind   = head.kind1;
			next_res.token_length = 8'd1;
			next_res.last         = 1'b1;
		end else begin
			next_res.token_kind   = head.tok0.kind;
			next_res.is_number    = head.tok0.is_number;
			next_res.is_hex       = head.tok0.is_hex;
			next_res.number_value = head.tok0.value;
			next_res.token_length = head.tok0.length;
			next_res.last         = !head.two;
		end
	end

	// drop the entry once its final result is loaded
	assign q_rd = load && (phase_q || !head.two);

	always_ff @(posedge clk) begin
		if (load)
			result_q <= next_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q && head.two;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result = result_q;
	assign empty  = !valid_q;

`ifndef ASSERT_OFF
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_q.last && pop) |=> valid_q)
		else $error("second result of a pair did not follow");
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !q_empty)
		else $error("pair pending with no entry at queue head");
	a_first_is_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_q.last) |-> (result_q.token_kind == KIND_WORD))
		else $error("non-last result is not a word");
`endif

endmodule
`default_nettype wire

// ===== sv/command_line_tokenizer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Command-line tokenizer: one character in, zero to two tokens out.
//
//   channel  handshake          payload
//   item     push / full        char_in, outermost
//   result   empty / pop        token_kind, is_number, is_hex, number_value,
//                               token_length, last
//
// One character is taken per cycle while full is low. A result passes through
// the entry queue and the output register before it shows on the result
// port. A word ended by a delimiter yields two results, which leave in turn;
// the entry queue of QUEUE_DEPTH absorbs such bursts, and full rises only
// when it is full. Reset clears the lexer state, the queue and the output.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	output logic           full,
	input  clt_pkg::in_t   item,
	output logic           empty,
	input  wire            pop,
	output clt_pkg::out_t  result
);
	import clt_pkg::*;

	logic   take;
	logic   q_wr, q_rd, q_full, q_empty;
	entry_t q_wdata, q_head;

	assign full = q_full;
	assign take = push && !q_full;

	clt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.wr     (q_wr),
		.entry  (q_wdata)
	);

	clt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	clt_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (q_head),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
`default_nettype wire
